// ===== rtl/pm_pkg.sv =====
// Package for the polynomial multiplier: sizes, payload types, cell control
// struct and state encoding. No dependencies.
package pm_pkg;

  localparam int MAX_TERMS = 16;                     // cells in the chain
  localparam int COEF_W    = 16;                     // Q8.8 coefficient width
  localparam int PROD_W    = 40;                     // Q24.16 sum width
  localparam int POW_W     = 5;                      // power field width
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);  // counts 0..MAX_TERMS
  localparam int MUL_W     = 2 * COEF_W;

  localparam logic KIND_FIRST  = 1'b0;
  localparam logic KIND_SECOND = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic        [PROD_W-1:0] sum_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic        [POW_W-1:0]  pow_t;

  typedef enum logic {
    S_IDLE,
    S_FLUSH
  } state_t;

  // Broadcast to every cell each cycle
  typedef struct packed {
    logic  load;   // write coef into the selected cell
    logic  mac;    // add a*coef into the handed-down sum
    logic  clear;  // drop the stored sums (new second polynomial)
    logic  shift;  // take the neighbor's sum
    coef_t coef;
  } cell_ctl_t;

endpackage

// ===== rtl/pm_if.sv =====
// Valid/ready channels of the polynomial multiplier: input items and results.
// Depends on pm_pkg.
interface pm_in_if;
  import pm_pkg::*;
  logic  valid;
  logic  ready;
  logic  kind;
  coef_t coefficient;
  logic  last;
  modport source (output valid, kind, coefficient, last, input ready);
  modport sink   (input valid, kind, coefficient, last, output ready);
endinterface

interface pm_out_if;
  import pm_pkg::*;
  logic valid;
  logic ready;
  sum_t product;
  pow_t power;
  logic final_res;
  logic overflow;
  modport source (output valid, product, power, final_res, overflow, input ready);
  modport sink   (input valid, product, power, final_res, overflow, output ready);
endinterface

// ===== rtl/pm_cell.sv =====
// One multiply-accumulate cell: holds one first-polynomial coefficient and
// one pending sum. Depends on pm_pkg.
module pm_cell (
  input  logic              clk,
  input  pm_pkg::cell_ctl_t ctl,
  input  logic              sel,     // this cell is the load target
  input  logic              active,  // index below the first length
  input  pm_pkg::sum_t      acc_in,  // from the higher neighbor
  output pm_pkg::sum_t      acc_out  // to the lower neighbor
);
  import pm_pkg::*;

  coef_t                    a;
  sum_t                     ps;
  logic signed [MUL_W-1:0]  mul;
  logic signed [PROD_W-1:0] prod;

  assign mul     = a * ctl.coef;
  assign prod    = PROD_W'(mul);   // sign-extend to the sum width
  assign acc_out = (ctl.clear ? '0 : ps) + ((ctl.mac && active) ? sum_t'(prod) : '0);

  always_ff @(posedge clk) begin
    if (ctl.load && sel) begin
      a <= ctl.coef;
    end
    if (ctl.shift) begin
      ps <= acc_in;
    end
  end

endmodule

// ===== rtl/polynomial_multiply.sv =====
// Top level of the polynomial multiplier: control FSM, output register and
// a chain of pm_cell. Depends on pm_pkg, pm_in_if, pm_out_if, pm_cell.
//
// Usage:
//  din carries items {kind, coefficient, last}. Kind 0 items load the first
//  polynomial A into the cells, lowest power first; last fixes its length
//  (saturating at MAX_TERMS). Kind 1 items stream the second polynomial B.
//  dout carries results {product, power, final_res, overflow}.
//  Output: a kind 1 item's result sits in the output register in the cycle
//  after acceptance. Kind 0 items produce nothing.
//  Throughput: one item per cycle; every cell does its multiply-accumulate
//  in parallel on the broadcast coefficient and hands its sum down the
//  chain. A kind 1 item with last set is followed by first_length-1 flush
//  results, one per cycle while dout takes them, shifted out of the chain;
//  din is held off during the flush.
//  B longer than MAX_TERMS gives one overflow result per extra item.
//  Stalls: while dout is not taken, the output register holds and din is
//  accepted only when the register frees in the same cycle.
//  Reset (rst, synchronous): clears the lengths, indexes, FSM and output
//  valid. No clearing pass; the sums are dropped at the start of each B.
module polynomial_multiply (
  input logic      clk,
  input logic      rst,
  pm_in_if.sink    din,
  pm_out_if.source dout
);
  import pm_pkg::*;

  // control registers
  state_t state, state_next;
  cnt_t   first_length;
  cnt_t   load_index;
  cnt_t   second_index;
  cnt_t   fl_left;   // flush results still to send
  pow_t   fl_pow;    // power of the next flush result

  cell_ctl_t ctl;
  sum_t      acc [MAX_TERMS+1];
  logic      sel    [MAX_TERMS];
  logic      active [MAX_TERMS];

  logic slot_free, take, take_a, take_b, b_ovf, b_mac, need_flush, flush_step;

  assign slot_free  = !dout.valid || dout.ready;
  assign take       = din.valid && din.ready;
  assign take_a     = take && (din.kind == KIND_FIRST);
  assign take_b     = take && (din.kind == KIND_SECOND);
  assign b_ovf      = take_b && (second_index >= cnt_t'(MAX_TERMS));
  assign b_mac      = take_b && !b_ovf;
  assign need_flush = b_mac && din.last && (first_length > cnt_t'(1));
  assign flush_step = (state == S_FLUSH) && slot_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (need_flush) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (flush_step && fl_left == cnt_t'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // FSM outputs: handshake and cell control
  always_comb begin
    din.ready = 1'b0;
    ctl.load  = 1'b0;
    ctl.mac   = 1'b0;
    ctl.clear = 1'b0;
    ctl.shift = 1'b0;
    ctl.coef  = din.coefficient;
    unique case (state)
      S_IDLE: begin
        din.ready = slot_free;
        ctl.load  = take_a && (load_index < cnt_t'(MAX_TERMS));
        ctl.mac   = b_mac;
        ctl.clear = b_mac && (second_index == '0);
        ctl.shift = b_mac;
      end
      S_FLUSH: begin
        ctl.shift = flush_step;   // shift pending sums down, no add
      end
      default: ;
    endcase
  end

  // cell chain; the top cell takes in zero
  assign acc[MAX_TERMS] = '0;
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    assign sel[i]    = (load_index == cnt_t'(i));
    assign active[i] = (cnt_t'(i) < first_length);
    pm_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .sel     (sel[i]),
      .active  (active[i]),
      .acc_in  (acc[i+1]),
      .acc_out (acc[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_length <= '0;
      load_index   <= '0;
      second_index <= '0;
      fl_left      <= '0;
      fl_pow       <= '0;
    end else begin
      state <= state_next;
      if (take_a) begin
        if (din.last) begin
          first_length <= load_index + cnt_t'(ctl.load);
          load_index   <= '0;
        end else if (ctl.load) begin
          load_index <= load_index + cnt_t'(1);
        end
      end
      if (b_ovf && din.last) begin
        second_index <= '0;
      end else if (b_mac) begin
        second_index <= din.last ? '0 : second_index + cnt_t'(1);
      end
      if (need_flush) begin
        fl_left <= first_length - cnt_t'(1);
        fl_pow  <= pow_t'(second_index) + pow_t'(1);
      end else if (flush_step) begin
        fl_left <= fl_left - cnt_t'(1);
        fl_pow  <= fl_pow + pow_t'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (take_b || flush_step) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ovf) begin
      dout.product   <= '0;
      dout.power     <= '0;
      dout.final_res <= 1'b0;
      dout.overflow  <= 1'b1;
    end else if (b_mac) begin
      dout.product   <= acc[0];
      dout.power     <= pow_t'(second_index);
      dout.final_res <= din.last && (first_length <= cnt_t'(1));
      dout.overflow  <= 1'b0;
    end else if (flush_step) begin
      dout.product   <= acc[0];
      dout.power     <= fl_pow;
      dout.final_res <= (fl_left == cnt_t'(1));
      dout.overflow  <= 1'b0;
    end
  end

  // checks
  a_ovf_fields: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.overflow |-> dout.product == '0 && dout.power == '0 && !dout.final_res)
    else $error("overflow result carries nonzero fields");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    second_index <= cnt_t'(MAX_TERMS) && first_length <= cnt_t'(MAX_TERMS))
    else $error("index beyond chain length");

  a_flush_count: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |-> fl_left != '0 && fl_left < first_length)
    else $error("flush count out of range");

  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    flush_step && fl_left == cnt_t'(1) |=> state == S_IDLE && dout.valid && dout.final_res)
    else $error("flush did not end on the final result");

endmodule

// ===== sim/pm_product_checker.sv =====
// Checker for the polynomial multiplier: watches both channels, predicts the
// product coefficients of every accepted item and compares them in order.
// Depends on pm_pkg and the pm_in_if / pm_out_if channels.
module pm_product_checker (
  input  logic clk,
  input  logic rst,
  pm_in_if     din,
  pm_out_if    dout,
  output int   fails,
  output int   pending,
  output int   n_results,
  output int   n_overflow
);
  import pm_pkg::*;

  typedef struct packed {
    sum_t product;
    pow_t power;
    logic final_res;
    logic overflow;
  } result_t;

  coef_t     a_coef [MAX_TERMS];  // first polynomial
  cnt_t      a_len;               // length of the last complete first polynomial
  cnt_t      a_fill;              // next slot to load
  sum_t      window [MAX_TERMS];  // pending sums, entry k is power b_pos+k
  cnt_t      b_pos;               // power of the next second coefficient
  result_t   product_q [$];       // expected results, oldest first
  int        err_cnt = 0;
  int        got_cnt = 0;
  int        ovf_cnt = 0;

  // Advance the predicted state by one item; queue what it produces.
  task automatic convolve_item(input logic k, input coef_t c, input logic l);
    logic signed [MUL_W-1:0]  term;
    logic signed [PROD_W-1:0] wide;
    sum_t                     acc;
    sum_t                     head;
    int                       span;
    result_t                  r;
    head = '0;
    if (k == KIND_FIRST) begin
      // written in place; extra coefficients past the end are dropped
      if (a_fill < MAX_TERMS) begin
        a_coef[a_fill] = c;
        a_fill++;
      end
      if (l) begin
        a_len  = a_fill;
        a_fill = '0;
      end
    end else if (b_pos >= MAX_TERMS) begin
      r = '0;
      r.overflow = 1'b1;
      product_q.push_back(r);
      if (l) b_pos = '0;
    end else begin
      if (b_pos == 0) begin
        for (int i = 0; i < MAX_TERMS; i++) window[i] = '0;
      end
      span = a_len;
      for (int i = 0; i < MAX_TERMS; i++) begin
        acc = window[i];
        if (i < span) begin
          term = a_coef[i] * c;
          wide = term;
          acc  = acc + sum_t'(wide);
        end
        if (i == 0) head = acc;
        else        window[i-1] = acc;
      end
      window[MAX_TERMS-1] = '0;
      // nothing loaded yet: A is the constant zero of length one
      if (span == 0) span = 1;
      r.product   = head;
      r.power     = pow_t'(b_pos);
      r.final_res = l && (span == 1);
      r.overflow  = 1'b0;
      product_q.push_back(r);
      if (l) begin
        for (int i = 0; i + 1 < span; i++) begin
          r.product   = window[i];
          r.power     = pow_t'(b_pos + 1 + i);
          r.final_res = (i + 2 == span);
          r.overflow  = 1'b0;
          product_q.push_back(r);
        end
        b_pos = '0;
      end else begin
        b_pos++;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_TERMS; i++) begin
        a_coef[i] = '0;
        window[i] = '0;
      end
      a_len  = '0;
      a_fill = '0;
      b_pos  = '0;
      product_q.delete();
    end else begin
      // results first, so an item taken at this edge cannot pair with them
      if (dout.valid && dout.ready) begin
        got_cnt++;
        if (dout.overflow) ovf_cnt++;
        if (product_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result product %h power %0d final %b ovf %b",
                   $time, dout.product, dout.power, dout.final_res, dout.overflow);
        end else begin
          want = product_q.pop_front();
          if (dout.product !== want.product) begin
            err_cnt++;
            $display("%0t: product at power %0d: expected %h, actual %h",
                     $time, want.power, want.product, dout.product);
          end
          if (dout.power !== want.power) begin
            err_cnt++;
            $display("%0t: power: expected %0d, actual %0d",
                     $time, want.power, dout.power);
          end
          if (dout.final_res !== want.final_res) begin
            err_cnt++;
            $display("%0t: final_res at power %0d: expected %b, actual %b",
                     $time, want.power, want.final_res, dout.final_res);
          end
          if (dout.overflow !== want.overflow) begin
            err_cnt++;
            $display("%0t: overflow: expected %b, actual %b",
                     $time, want.overflow, dout.overflow);
          end
        end
      end
      if (din.valid && din.ready) convolve_item(din.kind, din.coefficient, din.last);
    end
    fails      <= err_cnt;
    pending    <= product_q.size();
    n_results  <= got_cnt;
    n_overflow <= ovf_cnt;
  end

endmodule

// ===== sim/tb_polynomial_multiply.sv =====
// Testbench top for the polynomial multiplier: clock, reset, item stimulus,
// random output stalls and the verdict. Depends on pm_pkg, pm_if, the block
// and pm_product_checker.
module tb_polynomial_multiply;
  import pm_pkg::*;

  localparam int RANDOM_ITEMS = 300;

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic calm = 1'b0;  // no idling on either side while set

  int fails;
  int pending;
  int n_results;
  int n_overflow;
  int n_items = 0;
  int n_seq   = 0;
  int random_goal;

  pm_in_if  din_if ();
  pm_out_if dout_if ();

  polynomial_multiply DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  pm_product_checker product_chk (
    .clk        (clk),
    .rst        (rst),
    .din        (din_if),
    .dout       (dout_if),
    .fails      (fails),
    .pending    (pending),
    .n_results  (n_results),
    .n_overflow (n_overflow)
  );

  always #6 clk = ~clk;

  // Result side: about one cycle in ten stalled, none during the calm stretch
  always @(posedge clk) begin
    dout_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(12 * 200000);
    $display("timeout with %0d results still expected", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Coefficient mix: the extremes, small values and full-range noise
  function automatic coef_t pick_coef();
    case ($urandom_range(0, 9))
      0:       pick_coef = coef_t'(-32768);
      1:       pick_coef = coef_t'(32767);
      2:       pick_coef = coef_t'($urandom_range(0, 15)) - coef_t'(8);
      default: pick_coef = coef_t'($urandom);
    endcase
  endfunction

  // Mostly lengths that fit, now and then past MAX_TERMS
  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) pick_len = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
    else                           pick_len = $urandom_range(1, MAX_TERMS);
  endfunction

  // Present one item and hold it until the block takes it. Valid stays up
  // across back-to-back items; random idle cycles go in front.
  task automatic send_item(input logic k, input coef_t c, input logic l);
    while (!calm && $urandom_range(0, 99) < 10) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid       <= 1'b1;
    din_if.kind        <= k;
    din_if.coefficient <= c;
    din_if.last        <= l;
    do @(posedge clk); while (!din_if.ready);
    n_items++;
  endtask

  // Whole polynomial of one kind, last flag on the top coefficient
  task automatic send_poly(input logic k, input int len);
    for (int i = 0; i < len; i++) send_item(k, pick_coef(), i == len - 1);
  endtask

  // Hold the sender off until every expected product has arrived
  task automatic drain();
    din_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    din_if.valid       <= 1'b0;
    din_if.kind        <= KIND_FIRST;
    din_if.coefficient <= '0;
    din_if.last        <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // second polynomial with nothing loaded: A acts as constant zero
    send_item(KIND_SECOND, coef_t'(32767), 1'b0);
    send_item(KIND_SECOND, coef_t'(-32768), 1'b1);
    // extremes against extremes, length 2 by length 3
    send_item(KIND_FIRST, coef_t'(-32768), 1'b0);
    send_item(KIND_FIRST, coef_t'(32767), 1'b1);
    send_item(KIND_SECOND, coef_t'(-32768), 1'b0);
    send_item(KIND_SECOND, coef_t'(32767), 1'b0);
    send_item(KIND_SECOND, coef_t'(0), 1'b1);
    // reload in progress: new slot 0 is seen with the old length
    send_item(KIND_FIRST, coef_t'(-1), 1'b0);
    send_item(KIND_SECOND, coef_t'(5), 1'b1);
    send_item(KIND_FIRST, coef_t'(7), 1'b1);
    // single coefficient second polynomial gets the full flush
    send_item(KIND_SECOND, coef_t'(-256), 1'b1);
    // length one by length one: the only result is final
    send_item(KIND_FIRST, coef_t'(256), 1'b1);
    send_item(KIND_SECOND, coef_t'(-32768), 1'b1);
    drain();

    // --- random sequences ---
    random_goal = n_items + RANDOM_ITEMS;
    while (n_items < random_goal) begin
      n_seq++;
      calm <= (n_items >= random_goal - 200) && (n_items < random_goal - 120);
      if (n_seq == 1) begin
        // first polynomial too long: length saturates
        send_poly(KIND_FIRST, $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4));
      end else if (n_seq == 2) begin
        // second polynomial too long: overflow results, then recovery
        send_poly(KIND_SECOND, $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4));
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:29]:  send_poly(KIND_FIRST, pick_len());
          [30:84]: send_poly(KIND_SECOND, pick_len());
          default: begin
            // broken sequences: stray kinds and last flags
            repeat ($urandom_range(1, 4))
              send_item(logic'($urandom_range(0, 1)), pick_coef(),
                        logic'($urandom_range(0, 1)));
          end
        endcase
      end
      if (n_seq == 12) drain();
    end

    // --- wind down: everything back, then a few quiet cycles for strays ---
    calm <= 1'b0;
    din_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (MAX_TERMS + 8) @(posedge clk);

    $display("sent %0d items in %0d random sequences after the directed set",
             n_items, n_seq);
    $display("checked %0d product coefficients, %0d of them overflow results",
             n_results, n_overflow);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", fails);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
